// ===== rtl/kcl_pkg.sv =====
// Shared types and constants for the keypad code lock controller.
// Used by every module in the rtl folder; depends on nothing else.
`timescale 1ns / 1ps

package kcl_pkg;

    // Code length and the widths that follow from it.
    localparam int CODE_LENGTH = 4;
    localparam int POS_W       = $clog2(CODE_LENGTH + 1);
    localparam int IDX_W       = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;

    // Open-door timer and its register.
    localparam int          TIMER_W       = 24;
    localparam logic [23:0] TIMEOUT_RESET = 24'd3706425;

    // Remapped key codes.
    localparam logic [3:0] KEY_DIGIT_LIMIT = 4'd10;
    localparam logic [3:0] KEY_BACKSPACE   = 4'd10;
    localparam logic [3:0] KEY_ENTER       = 4'd11;
    localparam logic [3:0] KEY_LOCK        = 4'd12;
    localparam logic [3:0] KEY_CHANGE      = 4'd13;

    // Servo commands.
    localparam logic [1:0] SERVO_NONE   = 2'd0;
    localparam logic [1:0] SERVO_LOCKED = 2'd1;
    localparam logic [1:0] SERVO_OPEN   = 2'd2;

    // Message codes.
    localparam logic [3:0] MSG_NONE       = 4'd0;
    localparam logic [3:0] MSG_STAR       = 4'd1;
    localparam logic [3:0] MSG_ERASE      = 4'd2;
    localparam logic [3:0] MSG_ENTER      = 4'd3;
    localparam logic [3:0] MSG_WRONG      = 4'd4;
    localparam logic [3:0] MSG_CORRECT    = 4'd5;
    localparam logic [3:0] MSG_NOT_CLOSED = 4'd6;
    localparam logic [3:0] MSG_CLOSED     = 4'd7;
    localparam logic [3:0] MSG_OLD_PROMPT = 4'd8;
    localparam logic [3:0] MSG_NEW_PROMPT = 4'd9;
    localparam logic [3:0] MSG_DONE       = 4'd10;

    // One registered input word after key remapping.
    typedef struct packed {
        logic       valid;
        logic       tick;
        logic [3:0] key;
    } t_item;

    // Raw encoder codes above 7 lose 8, codes below 6 gain 8, 6 and 7 stay.
    function automatic logic [3:0] remap_key(input logic [3:0] raw);
        logic [3:0] key;
        if (raw > 4'd7) begin
            key = raw - 4'd8;
        end else if (raw < 4'd6) begin
            key = raw + 4'd8;
        end else begin
            key = raw;
        end
        return key;
    endfunction

endpackage

// ===== rtl/kcl_in_stage.sv =====
// Input register of the keypad code lock: captures one word and remaps its key.
// Depends on kcl_pkg.
`timescale 1ns / 1ps

module kcl_in_stage
    import kcl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  logic       i_in_valid,
    input  logic       i_kind,
    input  logic [3:0] i_key_code,
    output t_item      o_item
);

    logic       r_valid;
    logic       r_tick;
    logic [3:0] r_key;

    // The stage reloads whenever it is empty or its word moves on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_in_valid;
        end
        if (i_load && i_in_valid) begin
            r_tick <= i_kind;
            r_key  <= remap_key(i_key_code);
        end
    end

    assign o_item = '{valid: r_valid, tick: r_tick, key: r_key};

endmodule

// ===== rtl/kcl_core.sv =====
// Lock state machine, code stores, open timer and result register.
// Depends on kcl_pkg; fed by kcl_in_stage.
`timescale 1ns / 1ps

module kcl_core
    import kcl_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  t_item              i_item,
    input  logic [TIMER_W-1:0] i_open_timeout,
    output logic               o_out_valid,
    output logic [2:0]         o_mode,
    output logic [1:0]         o_servo_cmd,
    output logic               o_alarm,
    output logic [3:0]         o_message,
    output logic [2:0]         o_digits_entered
);

    typedef enum logic [2:0] {
        MODE_SET    = 3'd0,
        MODE_LOCKED = 3'd1,
        MODE_ENTER  = 3'd2,
        MODE_OPEN   = 3'd3,
        MODE_OLD    = 3'd4,
        MODE_NEW    = 3'd5
    } t_mode;

    // Lock state.
    t_mode              r_mode, n_mode;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [TIMER_W-1:0] r_timer, n_timer;
    logic               r_alarm, n_alarm;
    logic [3:0]         r_stored  [CODE_LENGTH];
    logic [3:0]         n_stored  [CODE_LENGTH];
    logic [3:0]         r_entered [CODE_LENGTH];
    logic [3:0]         n_entered [CODE_LENGTH];

    // Result register.
    logic       r_out_valid;
    logic [2:0] r_res_mode;
    logic [1:0] r_res_servo, n_servo;
    logic       r_res_alarm;
    logic [3:0] r_res_msg, n_msg;
    logic [2:0] r_res_digits, n_digits;

    // Helpers for the entry and timer paths.
    logic [POS_W-1:0]   pos_clamped;
    logic [IDX_W-1:0]   wr_idx;
    logic [POS_W-1:0]   pos_inc;
    logic               code_ok;
    logic [TIMER_W-1:0] limit;
    logic [TIMER_W-1:0] timer_inc;
    logic               is_key;

    // Write position, clamped to the last digit, and the code compare that
    // sees the digit being written this cycle.
    always_comb begin
        pos_clamped = (r_pos >= POS_W'(CODE_LENGTH)) ? POS_W'(CODE_LENGTH - 1) : r_pos;
        wr_idx      = pos_clamped[IDX_W-1:0];
        pos_inc     = pos_clamped + POS_W'(1);
        code_ok     = 1'b1;
        for (int n = 0; n < CODE_LENGTH; n++) begin
            if (((IDX_W'(n) == wr_idx) ? i_item.key : r_entered[n]) != r_stored[n]) begin
                code_ok = 1'b0;
            end
        end
        limit     = (i_open_timeout == '0) ? TIMER_W'(1) : i_open_timeout;
        timer_inc = r_timer + TIMER_W'(1);
        is_key    = !i_item.tick;
    end

    // Next state and result for the word in the input register.
    always_comb begin
        n_mode    = r_mode;
        n_pos     = r_pos;
        n_timer   = r_timer;
        n_alarm   = r_alarm;
        n_stored  = r_stored;
        n_entered = r_entered;
        n_servo   = SERVO_NONE;
        n_msg     = MSG_NONE;

        unique case (r_mode)
            MODE_OPEN: begin
                if (i_item.tick) begin
                    if (r_timer < limit) begin
                        n_timer = timer_inc;
                        if (timer_inc == limit) begin
                            n_alarm = 1'b1;
                            n_msg   = MSG_NOT_CLOSED;
                        end
                    end
                end else if (i_item.key == KEY_LOCK) begin
                    n_servo = SERVO_LOCKED;
                    n_alarm = 1'b0;
                    n_msg   = MSG_CLOSED;
                    n_mode  = MODE_LOCKED;
                end else begin
                    n_timer = '0;
                end
            end
            MODE_LOCKED: begin
                if (is_key && i_item.key == KEY_ENTER) begin
                    n_mode = MODE_ENTER;
                    n_pos  = '0;
                    n_msg  = MSG_ENTER;
                end else if (is_key && i_item.key == KEY_CHANGE) begin
                    n_mode = MODE_OLD;
                    n_pos  = '0;
                    n_msg  = MSG_OLD_PROMPT;
                end
            end
            MODE_SET, MODE_ENTER, MODE_OLD, MODE_NEW: begin
                if (is_key && i_item.key < KEY_DIGIT_LIMIT) begin
                    // Digit: store it and check for a complete entry.
                    if (r_mode == MODE_SET || r_mode == MODE_NEW) begin
                        n_stored[wr_idx] = i_item.key;
                    end else begin
                        n_entered[wr_idx] = i_item.key;
                    end
                    n_pos = pos_inc;
                    n_msg = MSG_STAR;
                    if (pos_inc >= POS_W'(CODE_LENGTH)) begin
                        n_pos = '0;
                        if (r_mode == MODE_SET) begin
                            n_mode  = MODE_LOCKED;
                            n_servo = SERVO_LOCKED;
                        end else if (r_mode == MODE_NEW) begin
                            n_mode  = MODE_LOCKED;
                            n_servo = SERVO_LOCKED;
                            n_msg   = MSG_DONE;
                        end else if (!code_ok) begin
                            n_mode  = MODE_LOCKED;
                            n_servo = SERVO_LOCKED;
                            n_msg   = MSG_WRONG;
                        end else if (r_mode == MODE_ENTER) begin
                            n_mode  = MODE_OPEN;
                            n_timer = '0;
                            n_servo = SERVO_OPEN;
                            n_msg   = MSG_CORRECT;
                        end else begin
                            n_mode = MODE_NEW;
                            n_msg  = MSG_NEW_PROMPT;
                        end
                    end
                end else if (is_key && i_item.key == KEY_BACKSPACE && r_pos != '0) begin
                    // Backspace at the first position is ignored.
                    n_pos = r_pos - POS_W'(1);
                    n_msg = MSG_ERASE;
                end
            end
            default: begin
                n_mode = MODE_LOCKED;
            end
        endcase

        n_digits = (n_mode == MODE_LOCKED || n_mode == MODE_OPEN) ? 3'd0 : 3'(n_pos);
    end

    // State and result registers; only valid moves with no word processed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_SET;
            r_pos       <= '0;
            r_timer     <= '0;
            r_alarm     <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_advance) begin
            r_out_valid <= i_item.valid;
            if (i_item.valid) begin
                r_mode  <= n_mode;
                r_pos   <= n_pos;
                r_timer <= n_timer;
                r_alarm <= n_alarm;
            end
        end
        if (i_advance && i_item.valid) begin
            r_stored     <= n_stored;
            r_entered    <= n_entered;
            r_res_mode   <= n_mode;
            r_res_servo  <= n_servo;
            r_res_alarm  <= n_alarm;
            r_res_msg    <= n_msg;
            r_res_digits <= n_digits;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_mode           = r_res_mode;
    assign o_servo_cmd      = r_res_servo;
    assign o_alarm          = r_res_alarm;
    assign o_message        = r_res_msg;
    assign o_digits_entered = r_res_digits;

endmodule

// ===== rtl/keypad_code_lock_controller.sv =====
// Keypad code lock controller: an input register, then one pass of lock logic into
// a result register; an accepted word passes the input register, then the result
// register. Throughput is one word per cycle; the input and result registers
// advance together whenever the result register is empty or being taken.
// Synchronous active-low reset empties both registers, enters the set-code mode
// and loads the open timeout with its default. Depends on kcl_pkg, kcl_in_stage, kcl_core.
`timescale 1ns / 1ps

module keypad_code_lock_controller
    import kcl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input channel.
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_kind,
    input  logic [3:0]  i_key_code,
    // Result channel.
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_mode,
    output logic [1:0]  o_servo_cmd,
    output logic        o_alarm,
    output logic [3:0]  o_message,
    output logic [2:0]  o_digits_entered,
    // Configuration channel for the open timeout.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [23:0] i_cfg_data
);

    logic [TIMER_W-1:0] r_timeout;
    t_item              item;
    logic               advance;
    logic               load;

    // Timeout register; writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_timeout <= i_cfg_data;
        end
    end

    // Pipeline flow: the core advances when its result register is empty or being taken.
    assign advance    = !o_out_valid || !i_out_stall;
    assign load       = advance || !item.valid;
    assign o_in_stall = item.valid && !advance;

    kcl_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_in_valid (i_in_valid),
        .i_kind     (i_kind),
        .i_key_code (i_key_code),
        .o_item     (item)
    );

    kcl_core u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_advance        (advance),
        .i_item           (item),
        .i_open_timeout   (r_timeout),
        .o_out_valid      (o_out_valid),
        .o_mode           (o_mode),
        .o_servo_cmd      (o_servo_cmd),
        .o_alarm          (o_alarm),
        .o_message        (o_message),
        .o_digits_entered (o_digits_entered)
    );

endmodule

// ===== verif/keypad_code_lock_controller_tb.sv =====
// Self-checking testbench for the keypad code lock controller: directed and random key words.
// Depends on kcl_pkg and the controller RTL; an in-line lock model predicts every result word.
`timescale 1ns / 1ps

module keypad_code_lock_controller_tb;
    import kcl_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_WORDS = 210;

    typedef enum logic [2:0] {
        MODE_SET,
        MODE_LOCKED,
        MODE_ENTER,
        MODE_OPEN,
        MODE_OLD,
        MODE_NEW
    } t_lock_mode;

    typedef struct packed {
        logic       tick;
        logic [3:0] raw;
    } t_key_event;

    typedef struct packed {
        logic [2:0] mode;
        logic [1:0] servo;
        logic       alarm;
        logic [3:0] message;
        logic [2:0] digits;
    } t_lock_word;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    logic        i_kind      = 1'b0;
    logic [3:0]  i_key_code  = 4'd0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [2:0]  o_mode;
    logic [1:0]  o_servo_cmd;
    logic        o_alarm;
    logic [3:0]  o_message;
    logic [2:0]  o_digits_entered;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [23:0] i_cfg_data  = 24'd0;

    // Lock state as the block should hold it after every accepted word.
    t_lock_mode  lk_mode    = MODE_SET;
    logic [3:0]  lk_stored  [CODE_LENGTH];
    logic [3:0]  lk_entered [CODE_LENGTH];
    logic [2:0]  lk_pos     = 3'd0;
    logic [23:0] lk_timer   = 24'd0;
    logic        lk_alarm   = 1'b0;
    logic [23:0] lk_timeout = TIMEOUT_RESET;

    t_key_event key_events[$];
    t_lock_word lock_results[$];

    int errors        = 0;
    int cycle_count   = 0;
    int queued_words  = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_left     = 0;

    always #2 i_clk = ~i_clk;

    keypad_code_lock_controller dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_kind           (i_kind),
        .i_key_code       (i_key_code),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_mode           (o_mode),
        .o_servo_cmd      (o_servo_cmd),
        .o_alarm          (o_alarm),
        .o_message        (o_message),
        .o_digits_entered (o_digits_entered),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    // Runs one accepted word through the lock logic and queues the result word it causes.
    function automatic void advance_lock(input logic tick, input logic [3:0] raw);
        logic [3:0]  key;
        logic [23:0] limit;
        logic        same;
        int          p;
        int          n;
        t_lock_word  w;
        w = '0;
        // Upper encoder codes fold down by 8, the lowest six fold up by 8.
        key = raw[3] ? {1'b0, raw[2:0]} : ((raw < 4'd6) ? raw + 4'd8 : raw);
        case (lk_mode)
            MODE_OPEN: begin
                if (tick) begin
                    // A zero timeout behaves like a timeout of one tick.
                    limit = (lk_timeout == 24'd0) ? 24'd1 : lk_timeout;
                    if (lk_timer < limit) begin
                        lk_timer = lk_timer + 24'd1;
                        if (lk_timer == limit) begin
                            lk_alarm  = 1'b1;
                            w.message = MSG_NOT_CLOSED;
                        end
                    end
                end else if (key == KEY_LOCK) begin
                    w.servo   = SERVO_LOCKED;
                    w.message = MSG_CLOSED;
                    lk_alarm  = 1'b0;
                    lk_mode   = MODE_LOCKED;
                end else begin
                    lk_timer = 24'd0;
                end
            end
            MODE_LOCKED: begin
                if (!tick && key == KEY_ENTER) begin
                    lk_mode   = MODE_ENTER;
                    lk_pos    = 3'd0;
                    w.message = MSG_ENTER;
                end else if (!tick && key == KEY_CHANGE) begin
                    lk_mode   = MODE_OLD;
                    lk_pos    = 3'd0;
                    w.message = MSG_OLD_PROMPT;
                end
            end
            default: begin
                // Entry modes: set, entering, old code and new code.
                if (!tick && key < KEY_DIGIT_LIMIT) begin
                    p = (lk_pos >= CODE_LENGTH) ? CODE_LENGTH - 1 : int'(lk_pos);
                    if (lk_mode == MODE_SET || lk_mode == MODE_NEW) begin
                        lk_stored[p] = key;
                    end else begin
                        lk_entered[p] = key;
                    end
                    lk_pos    = 3'(p + 1);
                    w.message = MSG_STAR;
                    if (lk_pos >= CODE_LENGTH) begin
                        lk_pos = 3'd0;
                        same   = 1'b1;
                        for (n = 0; n < CODE_LENGTH; n++) begin
                            if (lk_entered[n] != lk_stored[n]) begin
                                same = 1'b0;
                            end
                        end
                        if (lk_mode == MODE_SET) begin
                            lk_mode = MODE_LOCKED;
                            w.servo = SERVO_LOCKED;
                        end else if (lk_mode == MODE_NEW) begin
                            lk_mode   = MODE_LOCKED;
                            w.servo   = SERVO_LOCKED;
                            w.message = MSG_DONE;
                        end else if (!same) begin
                            lk_mode   = MODE_LOCKED;
                            w.servo   = SERVO_LOCKED;
                            w.message = MSG_WRONG;
                        end else if (lk_mode == MODE_ENTER) begin
                            lk_mode   = MODE_OPEN;
                            lk_timer  = 24'd0;
                            w.servo   = SERVO_OPEN;
                            w.message = MSG_CORRECT;
                        end else begin
                            lk_mode   = MODE_NEW;
                            w.message = MSG_NEW_PROMPT;
                        end
                    end
                end else if (!tick && key == KEY_BACKSPACE && lk_pos > 3'd0) begin
                    lk_pos    = lk_pos - 3'd1;
                    w.message = MSG_ERASE;
                end
            end
        endcase
        w.mode   = lk_mode;
        w.alarm  = lk_alarm;
        w.digits = (lk_mode == MODE_LOCKED || lk_mode == MODE_OPEN) ? 3'd0 : lk_pos;
        lock_results.push_back(w);
    endfunction

    function automatic void push_raw(input logic tick, input logic [3:0] raw);
        t_key_event ev;
        ev.tick = tick;
        ev.raw  = raw;
        key_events.push_back(ev);
        queued_words++;
    endfunction

    // Picks an encoder code that folds to the wanted key; 6 and 7 have two spellings.
    function automatic void push_key(input logic [3:0] key);
        logic [3:0] raw;
        if (key < 4'd6) begin
            raw = key + 4'd8;
        end else if (key > 4'd7) begin
            raw = key - 4'd8;
        end else begin
            raw = ($urandom_range(1) != 0) ? key : key + 4'd8;
        end
        push_raw(1'b0, raw);
    endfunction

    function automatic void push_tick();
        push_raw(1'b1, 4'($urandom_range(15)));
    endfunction

    // Types a code, now and then erasing and retyping a digit or hitting an ignored key.
    function automatic void push_digits(input logic [3:0] code [CODE_LENGTH]);
        int n;
        int r;
        for (n = 0; n < CODE_LENGTH; n++) begin
            push_key(code[n]);
            if (n < CODE_LENGTH - 1) begin
                r = $urandom_range(99);
                if (r < 10) begin
                    push_key(KEY_BACKSPACE);
                    push_key(code[n]);
                end else if (r < 14) begin
                    push_key(4'(KEY_ENTER + $urandom_range(2)));
                end else if (r < 17) begin
                    push_tick();
                end
            end
        end
    endfunction

    function automatic void push_random_code();
        logic [3:0] code [CODE_LENGTH];
        int n;
        for (n = 0; n < CODE_LENGTH; n++) begin
            code[n] = 4'($urandom_range(9));
        end
        push_digits(code);
    endfunction

    // Types the stored code, or a code that differs from it in at least one digit.
    function automatic logic push_entry(input logic want_match);
        logic [3:0] code [CODE_LENGTH];
        int n;
        int slot;
        for (n = 0; n < CODE_LENGTH; n++) begin
            code[n] = lk_stored[n];
        end
        if (!want_match) begin
            if ($urandom_range(1) != 0) begin
                for (n = 0; n < CODE_LENGTH; n++) begin
                    code[n] = 4'($urandom_range(9));
                end
            end
            slot       = $urandom_range(CODE_LENGTH - 1);
            code[slot] = 4'((lk_stored[slot] + 1 + $urandom_range(8)) % 10);
        end
        push_digits(code);
        return want_match;
    endfunction

    // Plans one user session from the lock state reached so far.
    function automatic void plan_session();
        int         r;
        int         n;
        logic [3:0] k;
        r = $urandom_range(99);
        case (lk_mode)
            MODE_LOCKED: begin
                if (r < 45) begin
                    push_key(KEY_ENTER);
                    void'(push_entry($urandom_range(99) < 65));
                end else if (r < 70) begin
                    push_key(KEY_CHANGE);
                    if (push_entry($urandom_range(99) < 60)) begin
                        push_random_code();
                    end
                end else begin
                    repeat ($urandom_range(4, 1)) begin
                        push_raw(1'($urandom_range(1)), 4'($urandom_range(15)));
                    end
                end
            end
            MODE_OPEN: begin
                // Short timeouts may get enough ticks to raise the alarm.
                n = (lk_timeout < 24'd12) ? $urandom_range(lk_timeout + 3) : $urandom_range(4);
                repeat (n) begin
                    if ($urandom_range(99) < 15) begin
                        k = 4'($urandom_range(12));
                        push_key((k == KEY_LOCK) ? KEY_CHANGE : k);
                    end else begin
                        push_tick();
                    end
                end
                if (r < 80) begin
                    push_key(KEY_LOCK);
                end
            end
            default: begin
                // Clear a partial entry; a spare backspace at the first position is ignored.
                repeat (lk_pos) push_key(KEY_BACKSPACE);
                if (r < 30) begin
                    push_key(KEY_BACKSPACE);
                end
                if (lk_mode == MODE_ENTER || lk_mode == MODE_OLD) begin
                    void'(push_entry($urandom_range(99) < 65));
                end else begin
                    push_random_code();
                end
            end
        endcase
    endfunction

    // Plans words that lead toward the open door.
    function automatic void plan_opening();
        case (lk_mode)
            MODE_LOCKED: begin
                push_key(KEY_ENTER);
                void'(push_entry(1'b1));
            end
            MODE_OPEN: begin
            end
            default: begin
                repeat (lk_pos) push_key(KEY_BACKSPACE);
                if (lk_mode == MODE_ENTER || lk_mode == MODE_OLD) begin
                    void'(push_entry(1'b1));
                end else begin
                    push_random_code();
                end
            end
        endcase
    endfunction

    task automatic set_traffic(input int idle, input int stall, input int hold);
        @(negedge i_clk);
        send_idle_pct = idle;
        stall_pct     = stall;
        hold_left     = hold;
    endtask

    // Waits until every queued word has been taken by the block.
    task automatic wait_fed();
        @(negedge i_clk);
        while (key_events.size() != 0 || i_in_valid) @(negedge i_clk);
    endtask

    task automatic wait_drained();
        wait_fed();
        while (lock_results.size() != 0) @(negedge i_clk);
    endtask

    // Writes the open timeout while the block is idle.
    task automatic write_timeout(input logic [23:0] value);
        wait_drained();
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        lk_timeout = value;
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic run_random(input int words);
        queued_words = 0;
        while (queued_words < words) begin
            wait_fed();
            plan_session();
        end
    endtask

    // Sender side: presents queued words and predicts each one the block accepts.
    always @(posedge i_clk) begin : word_feed
        logic       fire;
        logic       nxt_valid;
        logic       nxt_kind;
        logic [3:0] nxt_code;
        t_key_event ev;
        fire      = i_rst_n && i_in_valid && !o_in_stall;
        nxt_valid = i_in_valid && !fire;
        nxt_kind  = i_kind;
        nxt_code  = i_key_code;
        if (fire) begin
            advance_lock(i_kind, i_key_code);
        end
        if (!nxt_valid && i_rst_n && key_events.size() != 0 &&
            $urandom_range(99) >= send_idle_pct) begin
            ev        = key_events.pop_front();
            nxt_valid = 1'b1;
            nxt_kind  = ev.tick;
            nxt_code  = ev.raw;
        end
        i_in_valid <= nxt_valid;
        i_kind     <= nxt_kind;
        i_key_code <= nxt_code;
    end

    // Receiver side: checks each taken result word and drives the stall.
    always @(posedge i_clk) begin : result_check
        t_lock_word got;
        t_lock_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_mode, o_servo_cmd, o_alarm, o_message, o_digits_entered};
            if (lock_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected word mode=%0d servo=%0d alarm=%0d message=%0d digits=%0d",
                         $time, got.mode, got.servo, got.alarm, got.message, got.digits);
            end else begin
                want = lock_results.pop_front();
                if (got.mode !== want.mode || got.servo !== want.servo ||
                    got.alarm !== want.alarm || got.message !== want.message ||
                    got.digits !== want.digits) begin
                    errors++;
                    $display("%0t: expected mode=%0d servo=%0d alarm=%0d message=%0d digits=%0d",
                             $time, want.mode, want.servo, want.alarm, want.message,
                             want.digits);
                    $display("%0t: actual   mode=%0d servo=%0d alarm=%0d message=%0d digits=%0d",
                             $time, got.mode, got.servo, got.alarm, got.message, got.digits);
                end
            end
        end
        // A long hold lets the block fill up and stall its input.
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("keypad_code_lock_controller_tb: errors");
            $finish;
        end
    end

    initial begin : stimulus
        int n;
        for (n = 0; n < CODE_LENGTH; n++) begin
            lk_stored[n]  = 4'd0;
            lk_entered[n] = 4'd0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset timeout, no idling, a directed walk through the set, locked, entry and open modes first.
        set_traffic(0, 0, 0);
        push_tick();
        push_key(KEY_BACKSPACE);
        push_key(KEY_ENTER);
        push_key(KEY_LOCK);
        push_key(KEY_CHANGE);
        push_raw(1'b0, 4'd8);
        push_key(4'd9);
        push_key(KEY_BACKSPACE);
        push_raw(1'b0, 4'd15);
        push_raw(1'b0, 4'd6);
        push_key(4'd3);
        push_tick();
        push_key(4'd5);
        push_key(KEY_ENTER);
        push_raw(1'b0, 4'd0);
        push_key(4'd1);
        push_key(4'd2);
        push_key(4'd4);
        push_key(KEY_ENTER);
        push_key(4'd0);
        push_raw(1'b0, 4'd7);
        push_raw(1'b0, 4'd14);
        push_key(4'd3);
        push_key(4'd2);
        push_key(KEY_LOCK);
        run_random(PHASE_WORDS);

        write_timeout(24'd1);
        set_traffic(71, 0, 0);
        run_random(PHASE_WORDS);

        write_timeout(24'd0);
        set_traffic(0, 71, 0);
        run_random(PHASE_WORDS);

        write_timeout(24'hFFFFFF);
        set_traffic(25, 25, 80);
        run_random(PHASE_WORDS);

        write_timeout(24'd6);
        set_traffic(0, 0, 120);
        run_random(PHASE_WORDS);

        // Lower the timeout below the count already reached while the door is open.
        set_traffic(25, 25, 0);
        wait_fed();
        while (lk_mode != MODE_OPEN) begin
            plan_opening();
            wait_fed();
        end
        push_key(4'd5);
        repeat (4) push_tick();
        write_timeout(24'd3);
        repeat (5) push_tick();
        push_key(4'd5);
        repeat (3) push_tick();
        push_key(KEY_LOCK);
        run_random(PHASE_WORDS);

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("keypad_code_lock_controller_tb: clean");
        end else begin
            $display("keypad_code_lock_controller_tb: errors");
        end
        $finish;
    end

endmodule

// ===== keypad_code_lock_controller.f =====
rtl/kcl_pkg.sv
rtl/kcl_in_stage.sv
rtl/kcl_core.sv
rtl/keypad_code_lock_controller.sv
verif/keypad_code_lock_controller_tb.sv
